/* sv/dctd_pkg.sv */
// ----------------------------------------------------------------------------
// dctd_pkg: shared constants for the divisor count unit
// Operand width, result width and trial-division constants.
// ----------------------------------------------------------------------------
package dctd_pkg;

  localparam int WIDTH   = 32;
  localparam int TOTAL_W = 11;
  localparam int EXP_W   = $clog2(WIDTH + 1);
  localparam int BIT_W   = $clog2(WIDTH);

  localparam logic [WIDTH-1:0] FACTOR_THREE = WIDTH'(3);
  localparam logic [WIDTH-1:0] FIRST_CAND   = WIDTH'(5);
  localparam logic [WIDTH-1:0] STEP_LOW     = WIDTH'(2);
  localparam logic [WIDTH-1:0] STEP_HIGH    = WIDTH'(4);

  typedef logic [WIDTH-1:0]   word_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [EXP_W-1:0]   exp_t;
  typedef logic [BIT_W-1:0]   bit_cnt_t;

endpackage

/* sv/divisor_count_trial_division_unit.sv */
// ----------------------------------------------------------------------------
// divisor_count_trial_division_unit: counts positive divisors of an integer
// Twos are shifted out; one radix-2 divider tries 3, then 6k-1 and 6k+1.
// ----------------------------------------------------------------------------
// run time: a zero input is answered straight from idle; otherwise it grows
// with the trailing zeros and the number of trial divisions
// throughput: one transaction at a time, set by the one-bit-per-cycle divider
// reset: synchronous, clears the sequencer and the done strobe
// the receiver cannot stall: done is high for exactly one cycle per transaction
module divisor_count_trial_division_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          n_value,
  output logic                 busy,
  output logic                 done,
  output logic [10:0]          divisor_total,
  output logic                 invalid
);
  import dctd_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_FINAL = 3'd4;

  localparam logic [1:0] STG_THREE = 2'd0;
  localparam logic [1:0] STG_LOW   = 2'd1;
  localparam logic [1:0] STG_HIGH  = 2'd2;

  logic [2:0] state, state_next;
  logic [1:0] stage, stage_next;
  logic       first, first_next;
  word_t      v, v_next;
  word_t      divisor, divisor_next;
  word_t      rem, rem_next;
  word_t      quo, quo_next;
  bit_cnt_t   count, count_next;
  exp_t       e, e_next;
  total_t     product, product_next;
  logic       done_next;
  total_t     total_next;
  logic       invalid_next;

  word_t                      v_in;
  logic [WIDTH:0]             trial;
  logic                       fits;
  exp_t                       e_inc;
  total_t                     prod_wide;

  assign v_in      = WIDTH'(n_value);
  assign trial     = {rem, quo[WIDTH-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign e_inc     = e + EXP_W'(1);
  // the count only needs its low bits, so the product wraps at the result width
  assign prod_wide = product * TOTAL_W'(e_inc);
  assign busy      = state != ST_IDLE;

  always_comb begin
    state_next   = state;
    stage_next   = stage;
    first_next   = first;
    v_next       = v;
    divisor_next = divisor;
    rem_next     = rem;
    quo_next     = quo;
    count_next   = count;
    e_next       = e;
    product_next = product;
    done_next    = 1'b0;
    total_next   = divisor_total;
    invalid_next = invalid;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (v_in == '0) begin
            done_next    = 1'b1;
            total_next   = '0;
            invalid_next = 1'b1;
          end else begin
            v_next       = v_in;
            e_next       = '0;
            product_next = TOTAL_W'(1);
            state_next   = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        if (!v[0]) begin
          v_next = v >> 1;
          e_next = e_inc;
        end else begin
          product_next = prod_wide;
          e_next       = '0;
          divisor_next = FACTOR_THREE;
          stage_next   = STG_THREE;
          first_next   = 1'b0;
          rem_next     = '0;
          quo_next     = v;
          count_next   = BIT_W'(WIDTH - 1);
          state_next   = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_next = fits ? WIDTH'(trial - {1'b0, divisor}) : trial[WIDTH-1:0];
        quo_next = {quo[WIDTH-2:0], fits};
        count_next = count - BIT_W'(1);
        if (count == '0) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        rem_next   = '0;
        count_next = BIT_W'(WIDTH - 1);
        if (first && (divisor > quo)) begin
          // candidate squared exceeds the remaining value
          state_next = ST_FINAL;
        end else if (rem == '0) begin
          v_next     = quo;
          e_next     = e_inc;
          first_next = 1'b0;
          quo_next   = quo;
          state_next = ST_DIV;
        end else begin
          product_next = prod_wide;
          e_next       = '0;
          quo_next     = v;
          state_next   = ST_DIV;
          case (stage)
            STG_THREE: begin
              divisor_next = FIRST_CAND;
              stage_next   = STG_LOW;
              first_next   = 1'b1;
            end
            STG_LOW: begin
              divisor_next = divisor + STEP_LOW;
              stage_next   = STG_HIGH;
              first_next   = 1'b0;
            end
            default: begin
              divisor_next = divisor + STEP_HIGH;
              stage_next   = STG_LOW;
              first_next   = 1'b1;
            end
          endcase
        end
      end
      ST_FINAL: begin
        // a leftover value above one is one more prime
        total_next   = (v > WIDTH'(1)) ? (product << 1) : product;
        invalid_next = 1'b0;
        done_next    = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    stage         <= stage_next;
    first         <= first_next;
    v             <= v_next;
    divisor       <= divisor_next;
    rem           <= rem_next;
    quo           <= quo_next;
    count         <= count_next;
    e             <= e_next;
    product       <= product_next;
    divisor_total <= total_next;
    invalid       <= invalid_next;
  end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the trial-division divisor count unit
// Runs a table of directed operands, then random operands shaped so that the
// trial division stays short: smooth numbers, shifted small values and small
// integers. Results are checked against typed rows or a behavioral counter.
// ----------------------------------------------------------------------------
module tb_top;
  import dctd_pkg::*;

  typedef struct packed {
    word_t  n;
    total_t total;
    logic   invalid;
  } count_result_t;

  typedef struct packed {
    word_t  n;
    logic   typed;
    total_t total;
    logic   invalid;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 23;
  localparam int RANDOM_ITEMS  = 100;
  localparam int PENDING_DEPTH = DIRECTED_ROWS + RANDOM_ITEMS;
  localparam int PEND_W        = $clog2(PENDING_DEPTH + 1);
  localparam longint unsigned WORD_MAX = 64'h0000_0000_FFFF_FFFF;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  word_t  n_value = '0;
  logic   busy;
  logic   done;
  total_t divisor_total;
  logic   invalid;

  count_result_t pending_counts [PENDING_DEPTH];
  logic [PEND_W-1:0] pending_wr = '0;
  logic [PEND_W-1:0] pending_rd = '0;
  directed_row_t directed_rows [DIRECTED_ROWS];
  int unsigned   small_primes [25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                       43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};
  int unsigned   mismatch_count = 0;
  int unsigned   zero_gap_run = 0;

  divisor_count_trial_division_unit dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .n_value       (n_value),
    .busy          (busy),
    .done          (done),
    .divisor_total (divisor_total),
    .invalid       (invalid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #40000000;
    $display("Some tests failed");
    $finish;
  end

  // divide out every factor p, return the exponent
  function automatic longint unsigned strip_prime(inout longint unsigned rest,
                                                  input longint unsigned p);
    longint unsigned e;
    e = 0;
    while (rest % p == 0) begin
      rest = rest / p;
      e++;
    end
    return e;
  endfunction

  // n must be nonzero
  function automatic total_t divisor_count_of(word_t n);
    longint unsigned rest;
    longint unsigned product;
    longint unsigned cand;
    rest = 64'(n);
    product = strip_prime(rest, 2) + 1;
    product = product * (strip_prime(rest, 3) + 1);
    for (cand = 5; cand <= rest / cand; cand += 6) begin
      product = product * (strip_prime(rest, cand) + 1);
      product = product * (strip_prime(rest, cand + 2) + 1);
    end
    // leftover above one is a single large prime
    if (rest > 1) product = product * 2;
    return total_t'(product);
  endfunction

  function automatic count_result_t expected_count(word_t n);
    count_result_t r;
    r.n = n;
    if (n == '0) begin
      r.total   = '0;
      r.invalid = 1'b1;
    end else begin
      r.total   = divisor_count_of(n);
      r.invalid = 1'b0;
    end
    return r;
  endfunction

  // product of small primes, biased toward the smallest ones
  function automatic longint unsigned smooth_value(int unsigned steps);
    longint unsigned v;
    longint unsigned p;
    v = 1;
    for (int i = 0; i < steps; i++) begin
      p = 64'(small_primes[$urandom_range(0, $urandom_range(0, 24))]);
      if (v * p <= WORD_MAX) v = v * p;
    end
    return v;
  endfunction

  // operands whose largest cofactor stays small keep the divider loop short
  function automatic word_t pick_operand();
    int unsigned     kind;
    longint unsigned v;
    longint unsigned m;
    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      v = 0;
    end else if (kind < 5) begin
      v = 1;
    end else if (kind < 40) begin
      v = smooth_value($urandom_range(1, 40));
    end else if (kind < 70) begin
      m = 64'($urandom_range(1, 16383));
      v = (m << $urandom_range(0, 31)) & WORD_MAX;
    end else if (kind < 85) begin
      v = 64'($urandom_range(2, 65535));
    end else begin
      v = smooth_value($urandom_range(1, 20));
      m = 64'($urandom_range(2, 4095));
      if (v * m <= WORD_MAX) v = v * m;
    end
    return word_t'(v);
  endfunction

  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (zero_gap_run > 0) begin
      zero_gap_run--;
      return 0;
    end
    if (r < 5) zero_gap_run = $urandom_range(4, 12);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 20);
    return $urandom_range(21, 150);
  endfunction

  // start stays high across a zero gap so back-to-back transactions happen
  task automatic issue_count(count_result_t item, int unsigned gap);
    n_value <= item.n;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    pending_counts[pending_wr] = item;
    pending_wr = pending_wr + PEND_W'(1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_counts();
    while (pending_wr != pending_rd) @(posedge clk);
  endtask

  always @(posedge clk) begin
    count_result_t want;
    if (!rst && done) begin
      if (pending_wr == pending_rd) begin
        $display("%0t: unexpected result: divisor_total %0d invalid %0b",
                 $time, divisor_total, invalid);
        mismatch_count++;
      end else begin
        want = pending_counts[pending_rd];
        pending_rd = pending_rd + PEND_W'(1);
        if (divisor_total !== want.total) begin
          $display("%0t: n=%0d divisor_total expected %0d actual %0d",
                   $time, want.n, want.total, divisor_total);
          mismatch_count++;
        end
        if (invalid !== want.invalid) begin
          $display("%0t: n=%0d invalid expected %0b actual %0b",
                   $time, want.n, want.invalid, invalid);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    directed_row_t row;
    count_result_t item;
    directed_rows = '{
      '{32'd0,          1'b1, 11'd0,    1'b1},
      '{32'd1,          1'b1, 11'd1,    1'b0},
      '{32'd2,          1'b1, 11'd2,    1'b0},
      '{32'd3,          1'b1, 11'd2,    1'b0},
      '{32'd4,          1'b0, 11'd0,    1'b0},
      '{32'd5,          1'b1, 11'd2,    1'b0},
      '{32'd6,          1'b0, 11'd0,    1'b0},
      '{32'd10,         1'b0, 11'd0,    1'b0},
      '{32'd25,         1'b0, 11'd0,    1'b0},
      '{32'd35,         1'b0, 11'd0,    1'b0},
      '{32'd49,         1'b0, 11'd0,    1'b0},
      '{32'd121,        1'b0, 11'd0,    1'b0},
      '{32'd143,        1'b0, 11'd0,    1'b0},
      '{32'd169,        1'b0, 11'd0,    1'b0},
      '{32'd360,        1'b0, 11'd0,    1'b0},
      '{32'd0,          1'b1, 11'd0,    1'b1},
      '{32'd65537,      1'b1, 11'd2,    1'b0},
      '{32'd16777213,   1'b0, 11'd0,    1'b0},
      '{32'h8000_0000,  1'b1, 11'd32,   1'b0},
      '{32'hFFFF_FFFF,  1'b1, 11'd32,   1'b0},
      '{32'd3486784401, 1'b1, 11'd21,   1'b0},
      '{32'd735134400,  1'b1, 11'd1344, 1'b0},
      '{32'hFFFF_0000,  1'b0, 11'd0,    1'b0}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row  = directed_rows[i];
      item = expected_count(row.n);
      if (row.typed) begin
        item.total   = row.total;
        item.invalid = row.invalid;
      end
      issue_count(item, gap_cycles());
    end

    // hold off until the unit has gone fully idle
    start <= 1'b0;
    drain_counts();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      issue_count(expected_count(pick_operand()), gap_cycles());
      if (i == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        drain_counts();
      end
    end

    start <= 1'b0;
    drain_counts();
    repeat (200) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
